@@ sv/word_substring_replace_core_assert.svh @@
// Assertion macros shared by the word substring replace RTL.
`ifndef WORD_SUBSTRING_REPLACE_CORE_ASSERT_SVH
`define WORD_SUBSTRING_REPLACE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked property check, switched off during reset
`define WSR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be seen at a clock edge
`define WSR_NEVER(lbl, clk, rst, cond, msg) \
   `WSR_ASSERT(lbl, clk, rst, !(cond), msg)
`else
`define WSR_ASSERT(lbl, clk, rst, prop, msg)
`define WSR_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ sv/wsr_pkg.sv @@
// Types, constants and character helpers for the word substring replace core.
package wsr_pkg;

   localparam int unsigned WORD_MAX_DEF    = 32;
   localparam int unsigned PATTERN_MAX_DEF = 8;
   localparam int unsigned REPL_MAX_DEF    = 8;

   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned CFG_W     = 64;
   localparam int unsigned CFG_LEN_W = 4;
   localparam int unsigned CSR_IDX_W = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_BYTES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPL_BYTES    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REPL_LEN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IGNORE_CASE   = 3'd4;

   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0] HYPHEN_CHAR  = 8'h2D;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

   typedef logic [CHAR_W-1:0] char_type;

   // letters, digits and hyphen build a word
   function automatic logic is_word_char(input char_type c);
      return ((c >= "0") && (c <= "9")) || ((c >= "A") && (c <= "Z")) ||
             ((c >= "a") && (c <= "z")) || (c == HYPHEN_CHAR);
   endfunction

   // optional fold of upper case letters for comparison
   function automatic char_type fold_char(input char_type c, input logic ignore_case);
      if (ignore_case && (c >= "A") && (c <= "Z")) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   // byte idx of a packed 64-bit string, first byte lowest
   function automatic char_type packed_byte(input logic [CFG_W-1:0] packed_str,
                                            input logic [2:0] idx);
      return packed_str[idx*CHAR_W +: CHAR_W];
   endfunction

endpackage

@@ sv/wsr_word_buf.sv @@
// Word buffer: one write port, one read port with registered read data.
module wsr_word_buf
   import wsr_pkg::*;
#(
   parameter int unsigned DEPTH = WORD_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  char_type                 wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output char_type                 rd_data
);

   char_type mem [DEPTH];
   char_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/word_substring_replace_core.sv @@
// Top level of the word substring find and replace core.
`include "word_substring_replace_core_assert.svh"

// Bytes stream in on req_. Letters, digits and hyphen are stored into the word
// buffer. Any other byte ends the word: a sequencer then walks the candidate
// start positions with a single byte comparator, reading one buffer byte in
// S_FETCH and comparing it in S_CMP. On a match the rewritten word is sent as
// rsp_ beats: each stored byte is read from the buffer in S_EMIT and sent from
// S_LOAD, each replacement byte is sent from S_EMIT, and the closing newline
// goes out with rsp_tlast high. A word longer than WORD_MAX bytes is dropped.
// req_tready is high only while the sequencer is idle; the last beat of a word
// may still wait in the output register while the next bytes are taken.
// Configuration is written through csr_; the user must do so only while idle,
// as the block itself does not enforce it.
module word_substring_replace_core
   import wsr_pkg::*;
#(
   parameter int unsigned WORD_MAX        = WORD_MAX_DEF,
   parameter int unsigned PATTERN_MAX     = PATTERN_MAX_DEF,
   parameter int unsigned REPLACEMENT_MAX = REPL_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] in_char
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] out_char
   output logic                 rsp_tlast,   // last_of_word
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int unsigned LEN_W  = $clog2(WORD_MAX + 1);
   localparam int unsigned SUM_W  = LEN_W + 1;
   localparam int unsigned ADDR_W = $clog2(WORD_MAX);
   localparam int unsigned K_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_CMP,
      S_EMIT,
      S_LOAD
   } state_type;

   typedef enum logic [1:0] {
      SEG_PRE,
      SEG_REP,
      SEG_SUF,
      SEG_NL
   } seg_type;

   // configuration registers
   logic [CFG_W-1:0]     pat_bytes_ff;
   logic [CFG_LEN_W-1:0] pat_len_ff;
   logic [CFG_W-1:0]     rep_bytes_ff;
   logic [CFG_LEN_W-1:0] rep_len_ff;
   logic                 ign_case_ff;

   // sequencer state
   state_type        state_ff, state_in;
   seg_type          seg_ff, seg_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   char_type         rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   // buffer port
   logic              buf_wr_en;
   logic              buf_rd_en;
   logic [ADDR_W-1:0] buf_rd_addr;
   char_type          buf_rd_data;

   logic [CFG_LEN_W-1:0] plen;
   logic [CFG_LEN_W-1:0] rlen;
   logic [SUM_W-1:0]     pos_end;
   logic [SUM_W-1:0]     k_next;
   logic                 slot_free;
   logic                 in_fire;
   logic                 chars_equal;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff <= '0;
         pat_len_ff   <= CFG_LEN_W'(1);
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
         ign_case_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_PATTERN_BYTES: pat_bytes_ff <= csr_wdata;
            REG_PATTERN_LEN:   pat_len_ff   <= csr_wdata[CFG_LEN_W-1:0];
            REG_REPL_BYTES:    rep_bytes_ff <= csr_wdata;
            REG_REPL_LEN:      rep_len_ff   <= csr_wdata[CFG_LEN_W-1:0];
            REG_IGNORE_CASE:   ign_case_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // lengths saturate at their maxima
   assign plen = (pat_len_ff > CFG_LEN_W'(PATTERN_MAX)) ? CFG_LEN_W'(PATTERN_MAX) : pat_len_ff;
   assign rlen = (rep_len_ff > CFG_LEN_W'(REPLACEMENT_MAX)) ?
                 CFG_LEN_W'(REPLACEMENT_MAX) : rep_len_ff;

   assign pos_end     = SUM_W'(pos_ff) + SUM_W'(plen);
   assign k_next      = SUM_W'(k_ff) + SUM_W'(1);
   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == S_IDLE);
   assign in_fire     = req_tvalid && req_tready;
   assign chars_equal = fold_char(buf_rd_data, ign_case_ff) ==
                        fold_char(packed_byte(pat_bytes_ff, 3'(k_ff)), ign_case_ff);

   // sequencer: collect, search, emit
   always_comb begin
      state_in     = state_ff;
      seg_in       = seg_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      buf_wr_en    = 1'b0;
      buf_rd_en    = 1'b0;
      buf_rd_addr  = ADDR_W'(idx_ff);

      case (state_ff)
         S_IDLE: begin
            if (in_fire) begin
               if (is_word_char(req_tdata)) begin
                  if (len_ff < LEN_W'(WORD_MAX)) begin
                     buf_wr_en = 1'b1;
                     len_in    = len_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (ovf_ff || (plen == '0) ||
                            (SUM_W'(plen) > SUM_W'(len_ff))) begin
                  // nothing can match: drop the word
                  len_in = '0;
                  ovf_in = 1'b0;
               end else begin
                  pos_in   = '0;
                  k_in     = '0;
                  state_in = S_FETCH;
               end
            end
         end

         S_FETCH: begin
            buf_rd_en   = 1'b1;
            buf_rd_addr = ADDR_W'(SUM_W'(pos_ff) + SUM_W'(k_ff));
            state_in    = S_CMP;
         end

         S_CMP: begin
            if (chars_equal) begin
               if (k_next == SUM_W'(plen)) begin
                  seg_in   = SEG_PRE;
                  idx_in   = '0;
                  state_in = S_EMIT;
               end else begin
                  k_in     = K_W'(k_next);
                  state_in = S_FETCH;
               end
            end else if (pos_end == SUM_W'(len_ff)) begin
               // last candidate failed
               len_in   = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end else begin
               pos_in   = pos_ff + LEN_W'(1);
               k_in     = '0;
               state_in = S_FETCH;
            end
         end

         S_EMIT: begin
            case (seg_ff)
               SEG_PRE: begin
                  if (idx_ff == pos_ff) begin
                     seg_in = SEG_REP;
                     idx_in = '0;
                  end else begin
                     buf_rd_en = 1'b1;
                     state_in  = S_LOAD;
                  end
               end
               SEG_REP: begin
                  if (SUM_W'(idx_ff) == SUM_W'(rlen)) begin
                     seg_in = SEG_SUF;
                     idx_in = LEN_W'(pos_end);
                  end else if (slot_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = packed_byte(rep_bytes_ff, 3'(idx_ff));
                     rsp_last_in  = 1'b0;
                     idx_in       = idx_ff + LEN_W'(1);
                  end
               end
               SEG_SUF: begin
                  if (idx_ff == len_ff) begin
                     seg_in = SEG_NL;
                  end else begin
                     buf_rd_en = 1'b1;
                     state_in  = S_LOAD;
                  end
               end
               SEG_NL: begin
                  if (slot_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = NEWLINE_CHAR;
                     rsp_last_in  = 1'b1;
                     len_in       = '0;
                     ovf_in       = 1'b0;
                     state_in     = S_IDLE;
                  end
               end
               default: seg_in = SEG_PRE;
            endcase
         end

         S_LOAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = buf_rd_data;
               rsp_last_in  = 1'b0;
               idx_in       = idx_ff + LEN_W'(1);
               state_in     = S_EMIT;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seg_ff       <= SEG_PRE;
         pos_ff       <= '0;
         k_ff         <= '0;
         idx_ff       <= '0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         idx_ff       <= idx_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   wsr_word_buf #(
      .DEPTH (WORD_MAX)
   ) u_word_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (ADDR_W'(len_ff)),
      .wr_data (req_tdata),
      .rd_en   (buf_rd_en),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   // overflow only once the buffer is full
   `WSR_ASSERT(a_ovf_full, clock, reset, ovf_ff |-> (len_ff == LEN_W'(WORD_MAX)), "overflow below full")
   // every compared candidate lies inside the word
   `WSR_ASSERT(a_cand_inside, clock, reset, (state_ff == S_CMP) |-> (pos_end <= SUM_W'(len_ff)), "candidate past word end")
   // a beat marked last is always the newline
   `WSR_ASSERT(a_last_newline, clock, reset, (rsp_valid_ff && rsp_last_ff) |-> (rsp_data_ff == NEWLINE_CHAR), "last beat not newline")

endmodule
